[hdl/bfa_pkg.sv]
// Shared types and constants for the block fragment bitmap allocator.
package bfa_pkg;

	localparam int BLOCKS_DEF     = 16;
	localparam int SLOT_BYTES_DEF = 64;
	localparam int FRAGS          = 32;
	localparam int FRAG_W         = 5;
	localparam int MAX_BLK_W      = 6;
	localparam int SLOT_IDX_W     = MAX_BLK_W + FRAG_W;
	localparam int CNT_W          = 6;
	localparam int MASK_BLOCKS    = 16;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
	localparam logic [1:0] STAT_BAD_ADDR  = 2'd2;
	localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

	localparam logic [1:0] COND_FREE   = 2'd0;
	localparam logic [1:0] COND_ACTIVE = 2'd1;
	localparam logic [1:0] COND_FULL   = 2'd2;

	localparam logic [1:0] CFG_REGION_BASE   = 2'd0;
	localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd1;
	localparam logic [1:0] CFG_RESERVED_MASK = 2'd2;

	localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

	typedef struct packed {
		logic        action;
		logic [31:0] slot_address;
	} request_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0]  status;
	} result_t;

	// decoded request handed to the state stage
	typedef struct packed {
		logic                 valid;
		logic                 action;
		logic                 bad;
		logic [MAX_BLK_W-1:0] blk;
		logic [FRAG_W-1:0]    frag;
	} dec_req_t;

	// outcome of the state stage
	typedef struct packed {
		logic                  valid;
		logic                  grant;
		logic [1:0]            status;
		logic [SLOT_IDX_W-1:0] idx;
	} pick_t;

endpackage

[hdl/bfa_addr_decode.sv]
// Two-stage decode of a free address into block, fragment and a bad-address flag.
module bfa_addr_decode #(
	parameter int BLOCKS     = bfa_pkg::BLOCKS_DEF,
	parameter int SLOT_BYTES = bfa_pkg::SLOT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  bfa_pkg::request_t req,
	input  logic [31:0]       region_base,
	input  logic [4:0]        blocks_in_use,
	output bfa_pkg::dec_req_t dec
);
	import bfa_pkg::*;

	localparam int STRIDE = FRAGS * SLOT_BYTES;

	logic [31:0]          offset;
	logic [MAX_BLK_W-1:0] blk;
	logic                 bad_a;

	logic                 valid_s2;
	logic                 action_s2;
	logic                 bad_s2;
	logic [MAX_BLK_W-1:0] blk_s2;
	logic [31:0]          offset_s2;

	logic [31:0]          rem;
	logic [FRAG_W-1:0]    frag;
	logic                 mis;
	dec_req_t             dec_s3;

	always_comb begin
		offset = req.slot_address - region_base;
		blk = '0;
		for (int k = 1; k < BLOCKS; k++) begin
			if (offset >= 32'(k * STRIDE)) blk = MAX_BLK_W'(k);
		end
		bad_a = (req.slot_address < region_base) ||
			(offset >= 32'(BLOCKS * STRIDE)) ||
			({1'b0, blk} >= {2'b00, blocks_in_use});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		action_s2 <= req.action;
		bad_s2    <= bad_a;
		blk_s2    <= blk;
		offset_s2 <= offset;
	end

	always_comb begin
		rem = offset_s2 - 32'(blk_s2 * STRIDE);
		frag = '0;
		for (int j = 1; j < FRAGS; j++) begin
			if (rem >= 32'(j * SLOT_BYTES)) frag = FRAG_W'(j);
		end
		mis = rem != 32'(frag * SLOT_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s3 <= '0;
		end else begin
			dec_s3.valid  <= valid_s2;
			dec_s3.action <= action_s2;
			dec_s3.bad    <= bad_s2 || mis;
			dec_s3.blk    <= blk_s2;
			dec_s3.frag   <= frag;
		end
	end

	assign dec = dec_s3;

endmodule

[hdl/bfa_block_state.sv]
// Per-block occupancy maps, counts and conditions with the allocate/free update.
module bfa_block_state #(
	parameter int BLOCKS = bfa_pkg::BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_pkg::dec_req_t dec,
	input  logic [4:0]        blocks_in_use,
	input  logic [15:0]       reserved_mask,
	output bfa_pkg::pick_t    pick
);
	import bfa_pkg::*;

	localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

	logic [31:0]       map_q  [BLOCKS];
	logic [CNT_W-1:0]  cnt_q  [BLOCKS];
	logic [1:0]        cond_q [BLOCKS];

	logic [63:0]       rsv_ext;
	logic [BLOCKS-1:0] cand;
	logic              alloc_hit;
	logic [BW-1:0]     alloc_blk;
	logic [BW-1:0]     sel_blk;
	logic [31:0]       sel_map;
	logic [CNT_W-1:0]  sel_cnt;
	logic [FRAG_W-1:0] low_frag;
	logic [FRAG_W-1:0] sel_frag;
	logic              is_free;
	logic              do_set;
	logic              do_clr;
	logic [1:0]        stat;
	logic [31:0]       map_nxt;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [1:0]        cond_nxt;
	pick_t             pick_s4;

	always_comb begin
		rsv_ext = 64'(reserved_mask);
		for (int b = 0; b < BLOCKS; b++) begin
			cand[b] = (cond_q[b] != COND_FULL) && !rsv_ext[b] &&
				(7'(b) < {2'b00, blocks_in_use});
		end
		alloc_hit = |cand;
		alloc_blk = '0;
		for (int b = BLOCKS - 1; b >= 0; b--) begin
			if (cand[b]) alloc_blk = BW'(b);
		end

		is_free  = dec.action == ACT_FREE;
		sel_blk  = is_free ? dec.blk[BW-1:0] : alloc_blk;
		sel_map  = map_q[sel_blk];
		sel_cnt  = cnt_q[sel_blk];

		low_frag = '0;
		for (int f = FRAGS - 1; f >= 0; f--) begin
			if (!sel_map[f]) low_frag = FRAG_W'(f);
		end
		sel_frag = is_free ? dec.frag : low_frag;

		do_set = dec.valid && !is_free && alloc_hit;
		do_clr = dec.valid && is_free && !dec.bad && sel_map[dec.frag];

		if (!is_free) begin
			stat = alloc_hit ? STAT_OK : STAT_NO_SPACE;
		end else if (dec.bad) begin
			stat = STAT_BAD_ADDR;
		end else begin
			stat = sel_map[dec.frag] ? STAT_OK : STAT_NOT_ALLOC;
		end

		if (do_set) begin
			map_nxt  = sel_map | (32'd1 << sel_frag);
			cnt_nxt  = sel_cnt + CNT_W'(1);
			cond_nxt = (cnt_nxt >= CNT_W'(FRAGS)) ? COND_FULL : COND_ACTIVE;
		end else begin
			map_nxt  = sel_map & ~(32'd1 << sel_frag);
			cnt_nxt  = sel_cnt - CNT_W'(1);
			cond_nxt = (cnt_nxt == '0) ? COND_FREE : COND_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BLOCKS; b++) begin
				map_q[b]  <= '0;
				cnt_q[b]  <= '0;
				cond_q[b] <= COND_FREE;
			end
		end else if (do_set || do_clr) begin
			map_q[sel_blk]  <= map_nxt;
			cnt_q[sel_blk]  <= cnt_nxt;
			cond_q[sel_blk] <= cond_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_s4 <= '0;
		end else begin
			pick_s4.valid  <= dec.valid;
			pick_s4.grant  <= do_set;
			pick_s4.status <= stat;
			pick_s4.idx    <= {MAX_BLK_W'(sel_blk), sel_frag};
		end
	end

	assign pick = pick_s4;

endmodule

[hdl/block_fragment_bitmap_allocator_unit.sv]
// Top level of the block fragment bitmap allocator: config, request intake and result.
// One allocate or free request is taken per cycle (busy stays low); result_valid
// rises after the request has passed the intake register, the decode registers, the
// state register and the result register. Results come in request order and the
// receiver cannot stall them. The map update in the state stage lets each request
// see the effect of the one before it, which sets the rate of one request per cycle.
// All occupancy maps are cleared by reset at once; there is no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
module block_fragment_bitmap_allocator_unit #(
	parameter int BLOCKS     = bfa_pkg::BLOCKS_DEF,
	parameter int SLOT_BYTES = bfa_pkg::SLOT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfa_pkg::request_t request,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	output logic              result_valid,
	output bfa_pkg::result_t  result
);
	import bfa_pkg::*;

	logic [31:0] region_base_q;
	logic [4:0]  blocks_in_use_q;
	logic [15:0] reserved_mask_q;

	logic        valid_s1;
	request_t    req_s1;
	dec_req_t    dec;
	pick_t       pick;
	logic [31:0] grant_addr;
	logic        result_valid_q;
	result_t     result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q   <= '0;
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
			reserved_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_BASE:   region_base_q   <= cfg_wdata;
				CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata[4:0];
				CFG_RESERVED_MASK: reserved_mask_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	bfa_addr_decode #(
		.BLOCKS(BLOCKS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid_s1),
		.req(req_s1),
		.region_base(region_base_q),
		.blocks_in_use(blocks_in_use_q),
		.dec(dec)
	);

	bfa_block_state #(
		.BLOCKS(BLOCKS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.dec(dec),
		.blocks_in_use(blocks_in_use_q),
		.reserved_mask(reserved_mask_q),
		.pick(pick)
	);

	assign grant_addr = region_base_q + 32'(pick.idx * SLOT_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= pick.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.granted_address <= pick.grant ? grant_addr : '0;
		result_q.status          <= pick.status;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 result_valid)
		else $error("request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !result_valid)
		else $error("result without request");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != STAT_OK) |-> result.granted_address == '0)
		else $error("failed request carries an address");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the block fragment bitmap allocator unit.
`timescale 1ns / 1ps

module tb_top;
	import bfa_pkg::*;

	localparam int          BLOCKS     = 16;
	localparam int          SLOT_BYTES = 64;
	localparam int unsigned STRIDE     = FRAGS * SLOT_BYTES;
	localparam int          NPHASE     = 8;
	localparam int          PHASE_REQS = 200;
	localparam int          QUIET_MAX  = 2000;

	class slot_ledger;
		logic [31:0] region_base;
		logic [4:0]  blocks_in_use;
		logic [15:0] reserved_mask;
		logic [31:0] occ [BLOCKS];
		logic [5:0]  cnt [BLOCKS];
		logic [1:0]  cond [BLOCKS];
		result_t     grants_due [$];
		int          errors;
		int          requests;
		int          stat_seen [4];

		function new();
			region_base   = '0;
			blocks_in_use = BLOCKS_IN_USE_RST;
			reserved_mask = '0;
			for (int b = 0; b < BLOCKS; b++) begin
				occ[b]  = '0;
				cnt[b]  = '0;
				cond[b] = COND_FREE;
			end
			errors   = 0;
			requests = 0;
			for (int s = 0; s < 4; s++)
				stat_seen[s] = 0;
		endfunction

		function int unsigned usable();
			return (blocks_in_use > BLOCKS) ? BLOCKS : blocks_in_use;
		endfunction

		function bit is_reserved(int unsigned b);
			return b < MASK_BLOCKS && reserved_mask[b];
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_REGION_BASE:   region_base = val;
				CFG_BLOCKS_IN_USE: blocks_in_use = val[4:0];
				CFG_RESERVED_MASK: reserved_mask = val[15:0];
				default: ;
			endcase
		endfunction

		function result_t predict_alloc();
			result_t     r;
			int unsigned lim;
			int unsigned f;
			r.granted_address = '0;
			r.status          = STAT_NO_SPACE;
			lim = usable();
			for (int unsigned b = 0; b < lim; b++) begin
				if (cond[b] == COND_FULL || is_reserved(b) || occ[b] == 32'hFFFF_FFFF)
					continue;
				f = 0;
				while (occ[b][f])
					f++;
				occ[b][f] = 1'b1;
				cnt[b]    = cnt[b] + 6'd1;
				cond[b]   = (cnt[b] >= FRAGS) ? COND_FULL : COND_ACTIVE;
				r.granted_address = region_base + b * STRIDE + f * SLOT_BYTES;
				r.status          = STAT_OK;
				return r;
			end
			return r;
		endfunction

		function result_t predict_free(logic [31:0] addr);
			result_t     r;
			logic [31:0] off;
			int unsigned blk;
			int unsigned frag;
			r.granted_address = '0;
			if (addr < region_base) begin
				r.status = STAT_BAD_ADDR;
				return r;
			end
			off = addr - region_base;
			blk = off / STRIDE;
			if (blk >= usable() || (off % SLOT_BYTES) != 0) begin
				r.status = STAT_BAD_ADDR;
				return r;
			end
			frag = (off % STRIDE) / SLOT_BYTES;
			if (!occ[blk][frag]) begin
				r.status = STAT_NOT_ALLOC;
				return r;
			end
			occ[blk][frag] = 1'b0;
			cnt[blk]  = cnt[blk] - 6'd1;
			cond[blk] = (cnt[blk] == 0) ? COND_FREE : COND_ACTIVE;
			r.status  = STAT_OK;
			return r;
		endfunction

		function void note_request(request_t req);
			requests++;
			if (req.action == ACT_ALLOC)
				grants_due.push_back(predict_alloc());
			else
				grants_due.push_back(predict_free(req.slot_address));
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (grants_due.size() == 0) begin
				report($sformatf("result with no request pending: addr=%h status=%0d",
					got.granted_address, got.status));
				return;
			end
			want = grants_due.pop_front();
			stat_seen[want.status]++;
			if (got.granted_address !== want.granted_address)
				report($sformatf("granted_address %h, want %h (status want %0d)",
					got.granted_address, want.granted_address, want.status));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
		endtask

		function int pending();
			return grants_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	request_t    request = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_REGION_BASE;
	logic [31:0] cfg_wdata = '0;
	logic        result_valid;
	result_t     result;

	slot_ledger  sb;
	int          settings = 0;
	int          quiet_cycles = 0;
	bit          no_idle = 1'b0;

	block_fragment_bitmap_allocator_unit #(
		.BLOCKS    (BLOCKS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.result_valid(result_valid),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(request);
			if (result_valid)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("watchdog: %0d cycles without activity", quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_free_addr();
		int unsigned lim;
		int unsigned b;
		int unsigned f;
		int          r;
		logic [31:0] slot;
		lim = sb.usable();
		r   = $urandom_range(0, 99);
		if (lim == 0 || r >= 90)
			return $urandom;
		if (r < 60) begin
			for (int i = 0; i < 8; i++) begin
				b = $urandom_range(0, lim - 1);
				f = $urandom_range(0, FRAGS - 1);
				if (sb.occ[b][f])
					return sb.region_base + b * STRIDE + f * SLOT_BYTES;
			end
		end
		b    = $urandom_range(0, lim);
		f    = $urandom_range(0, FRAGS - 1);
		slot = sb.region_base + b * STRIDE + f * SLOT_BYTES;
		if (r >= 80)
			return slot + $urandom_range(1, SLOT_BYTES - 1);
		return slot;
	endfunction

	task automatic send_request(logic act, logic [31:0] addr);
		request_t q;
		int       gap;
		gap            = gap_len();
		q.action       = act;
		q.slot_address = addr;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= q;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_alloc();
		send_request(ACT_ALLOC, $urandom);
	endtask

	task automatic send_free(logic [31:0] addr);
		send_request(ACT_FREE, addr);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// upper bits of the narrow registers get random filler half of the time
	task automatic apply_setting(logic [31:0] base, logic [4:0] blk_lim, logic [15:0] mask);
		logic [31:0] fill;
		drain_results();
		fill = $urandom_range(0, 1) ? $urandom : 32'd0;
		write_reg(CFG_REGION_BASE, base);
		write_reg(CFG_BLOCKS_IN_USE, {fill[31:5], blk_lim});
		write_reg(CFG_RESERVED_MASK, {fill[31:16], mask});
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(int alloc_pct, bit pause_mid);
		for (int i = 0; i < PHASE_REQS; i++) begin
			if (pause_mid && i == PHASE_REQS / 2)
				drain_results();
			if ($urandom_range(1, 100) <= alloc_pct)
				send_alloc();
			else
				send_free(pick_free_addr());
		end
	endtask

	initial begin
		logic [31:0] base;
		logic [4:0]  blk_lim;
		logic [15:0] mask;
		int          r;
		int          pct;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: lowest-first grants, double free, bad addresses
		no_idle = 1'b1;
		send_alloc();
		send_alloc();
		send_alloc();
		send_free(32'd64);
		send_free(32'd64);
		send_alloc();
		send_free(32'd1);
		send_free(BLOCKS * STRIDE);
		send_free(32'hFFFF_FFFF);
		send_free(3 * STRIDE);
		// no usable block
		apply_setting(32'd0, 5'd0, 16'h0000);
		send_alloc();
		send_free(32'd0);
		// block limit above the block count, free below base
		apply_setting(32'h0000_1000, 5'd20, 16'h0000);
		send_free(32'h0000_0FC0);
		send_free(32'h0000_1000);
		send_alloc();
		// reserved block skipped, freed after becoming reserved
		apply_setting(32'd0, 5'd2, 16'h0001);
		send_alloc();
		send_free(32'd128);
		send_free(32'd192);
		apply_setting(32'd0, 5'd16, 16'hFFFF);
		send_alloc();
		send_free(STRIDE);
		// address wrap past 2^32
		apply_setting(32'hFFFF_FFC0, 5'd16, 16'h0000);
		send_alloc();
		send_alloc();
		send_free(32'hFFFF_FFC0);
		send_free(32'h0000_0040);

		for (int p = 0; p < NPHASE; p++) begin
			no_idle = (p % 3 == 1);
			case (p)
				0: begin
					base = 32'd0; blk_lim = 5'd1; mask = 16'h0000; pct = 85;
				end
				1: begin
					base = 32'hFFFF_FFFF; blk_lim = 5'd31; mask = 16'hFFFF; pct = 50;
				end
				2: begin
					base = 32'd0; blk_lim = 5'd16; mask = 16'h0000; pct = 80;
				end
				7: begin
					base = 32'd0; blk_lim = 5'd16; mask = 16'h0000; pct = 30;
				end
				default: begin
					r = $urandom_range(0, 3);
					case (r)
						0: base = 32'd0;
						1: base = 32'hFFFF_8000 + ($urandom_range(0, 511) << 6);
						2: base = $urandom;
						default: base = $urandom & ~32'h3F;
					endcase
					r = $urandom_range(0, 4);
					case (r)
						0: blk_lim = 5'($urandom_range(0, 31));
						1: blk_lim = 5'($urandom_range(1, 3));
						2: blk_lim = 5'd16;
						3: blk_lim = 5'($urandom_range(17, 31));
						default: blk_lim = 5'($urandom_range(4, 15));
					endcase
					r = $urandom_range(0, 3);
					case (r)
						0: mask = 16'h0000;
						1: mask = 16'h0001 << $urandom_range(0, 15);
						2: mask = 16'($urandom);
						default: mask = 16'($urandom & $urandom);
					endcase
					pct = 25 * $urandom_range(1, 3);
				end
			endcase
			apply_setting(base, blk_lim, mask);
			run_phase(pct, p == 2);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("Covered %0d requests over %0d register settings.", sb.requests, settings);
		$display("Outcomes: %0d ok, %0d no space, %0d bad address, %0d not allocated.",
			sb.stat_seen[STAT_OK], sb.stat_seen[STAT_NO_SPACE],
			sb.stat_seen[STAT_BAD_ADDR], sb.stat_seen[STAT_NOT_ALLOC]);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
